// ===== hdl/lgb_pkg.sv =====
// ----------------------------------------------------------------------------
// lgb_pkg
// Shared types and constants of the linear gradient brush sampler.
// ----------------------------------------------------------------------------
package lgb_pkg;

	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int REM_W   = PROD_W + 1;
	localparam int CHAN_W  = 8;
	localparam int NCHAN   = 4;
	localparam int COLOR_W = CHAN_W * NCHAN;
	localparam int OPAC_W  = 9;
	localparam int KIND_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [KIND_W-1:0] BRUSH_SOLID  = 2'd0;
	localparam logic [KIND_W-1:0] BRUSH_LINEAR = 2'd1;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
	localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hFFFF_FFFF;
	localparam logic [OPAC_W-1:0] OPAC_RESET = 9'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BRUSH_KIND = 3'd0,
		CFG_START_X    = 3'd1,
		CFG_START_Y    = 3'd2,
		CFG_END_X      = 3'd3,
		CFG_END_Y      = 3'd4,
		CFG_COLOR_A    = 3'd5,
		CFG_COLOR_B    = 3'd6,
		CFG_OPACITY    = 3'd7
	} cfg_idx_t;

	// class of the projection parameter: zero, one, or a true quotient
	typedef enum logic [1:0] {
		TCLS_ZERO = 2'd0,
		TCLS_ONE  = 2'd1,
		TCLS_DIV  = 2'd2
	} tcls_t;

	typedef struct packed {
		logic  valid;
		tcls_t cls;
	} lgb_ctl_t;

endpackage

// ===== hdl/lgb_div.sv =====
// ----------------------------------------------------------------------------
// lgb_div
// Pipelined restoring divider: one quotient bit per stage, giving the
// projection parameter t = floor(dot * 2^T / len2) as an unsigned fraction, or 0 or 1.0 by class.
// ----------------------------------------------------------------------------
module lgb_div #(
	parameter int T_FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  lgb_pkg::lgb_ctl_t               ctl_in,
	input  logic [lgb_pkg::REM_W-1:0]       dot_in,
	input  logic [lgb_pkg::REM_W-1:0]       len_in,
	output lgb_pkg::lgb_ctl_t               ctl_out,
	output logic [T_FRAC_BITS:0]            t_out
);
	import lgb_pkg::*;

	localparam int TW = T_FRAC_BITS + 1;
	localparam logic [TW-1:0] ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

	lgb_ctl_t               ctl_s   [T_FRAC_BITS];
	logic [REM_W-1:0]       rem_s   [T_FRAC_BITS];
	logic [REM_W-1:0]       len_s   [T_FRAC_BITS];
	logic [T_FRAC_BITS-1:0] quo_s   [T_FRAC_BITS];

	lgb_ctl_t               ctl_src [T_FRAC_BITS];
	logic [REM_W-1:0]       rem_src [T_FRAC_BITS];
	logic [REM_W-1:0]       len_src [T_FRAC_BITS];
	logic [T_FRAC_BITS-1:0] quo_src [T_FRAC_BITS];
	logic [REM_W-1:0]       shifted [T_FRAC_BITS];
	logic                   ge      [T_FRAC_BITS];
	logic [REM_W-1:0]       rem_nx  [T_FRAC_BITS];
	logic [T_FRAC_BITS-1:0] quo_nx  [T_FRAC_BITS];

	always_comb begin
		ctl_src[0] = ctl_in;
		rem_src[0] = dot_in;
		len_src[0] = len_in;
		quo_src[0] = '0;
		for (int k = 1; k < T_FRAC_BITS; k++) begin
			ctl_src[k] = ctl_s[k-1];
			rem_src[k] = rem_s[k-1];
			len_src[k] = len_s[k-1];
			quo_src[k] = quo_s[k-1];
		end
		for (int k = 0; k < T_FRAC_BITS; k++) begin
			shifted[k] = {rem_src[k][REM_W-2:0], 1'b0};
			ge[k]      = (shifted[k] >= len_src[k]);
			rem_nx[k]  = ge[k] ? (shifted[k] - len_src[k]) : shifted[k];
			quo_nx[k]  = {quo_src[k][T_FRAC_BITS-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < T_FRAC_BITS; k++) begin
				ctl_s[k] <= '0;
			end
		end else if (en) begin
			for (int k = 0; k < T_FRAC_BITS; k++) begin
				ctl_s[k] <= ctl_src[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < T_FRAC_BITS; k++) begin
				rem_s[k] <= rem_nx[k];
				len_s[k] <= len_src[k];
				quo_s[k] <= quo_nx[k];
			end
		end
	end

	assign ctl_out = ctl_s[T_FRAC_BITS-1];

	always_comb begin
		case (ctl_s[T_FRAC_BITS-1].cls)
			TCLS_ONE: t_out = ONE;
			TCLS_DIV: t_out = {1'b0, quo_s[T_FRAC_BITS-1]};
			default:  t_out = '0;
		endcase
	end

endmodule

// ===== hdl/linear_gradient_brush_sampler.sv =====
// ----------------------------------------------------------------------------
// linear_gradient_brush_sampler
// Samples a solid, linear gradient or white brush at one pixel position and
// returns RGBA bytes with alpha scaled by opacity.
// ----------------------------------------------------------------------------
// Takes one pixel position per clock while in_stall is low and returns one RGBA
// result per position, in order. Three stages form the offsets, the dot product
// and the squared length, the divider resolves one bit of t per stage
// (T_FRAC_BITS stages), three more stages mix the colors and scale alpha, and
// one output register drives the ports. A two-entry output buffer absorbs a
// stall, so in_stall rises only when a result arrives while the output is full
// and the consumer holds it off. The user must write configuration registers
// through cfg_we only while no transaction is in flight; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module linear_gradient_brush_sampler #(
	parameter int T_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lgb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lgb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [lgb_pkg::COORD_W-1:0] pos_x,
	input  logic signed [lgb_pkg::COORD_W-1:0] pos_y,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [lgb_pkg::CHAN_W-1:0]         red,
	output logic [lgb_pkg::CHAN_W-1:0]         green,
	output logic [lgb_pkg::CHAN_W-1:0]         blue,
	output logic [lgb_pkg::CHAN_W-1:0]         alpha
);
	import lgb_pkg::*;

	localparam int TW  = T_FRAC_BITS + 1;
	localparam int MIXP_W = CHAN_W + TW;
	localparam int MIXS_W = MIXP_W + 1;
	localparam int APROD_W = CHAN_W + OPAC_W;
	localparam logic [TW-1:0] ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

	logic [KIND_W-1:0]        brush_kind_q;
	logic signed [COORD_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic [COLOR_W-1:0]       color_a_q, color_b_q;
	logic [OPAC_W-1:0]        opacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brush_kind_q <= BRUSH_SOLID;
			start_x_q    <= '0;
			start_y_q    <= '0;
			end_x_q      <= '0;
			end_y_q      <= '0;
			color_a_q    <= COLOR_RESET;
			color_b_q    <= COLOR_RESET;
			opacity_q    <= OPAC_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BRUSH_KIND: brush_kind_q <= cfg_data[KIND_W-1:0];
				CFG_START_X:    start_x_q    <= cfg_data[COORD_W-1:0];
				CFG_START_Y:    start_y_q    <= cfg_data[COORD_W-1:0];
				CFG_END_X:      end_x_q      <= cfg_data[COORD_W-1:0];
				CFG_END_Y:      end_y_q      <= cfg_data[COORD_W-1:0];
				CFG_COLOR_A:    color_a_q    <= cfg_data[COLOR_W-1:0];
				CFG_COLOR_B:    color_b_q    <= cfg_data[COLOR_W-1:0];
				CFG_OPACITY:    opacity_q    <= cfg_data[OPAC_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic sk_v_q;

	assign en       = !sk_v_q;
	assign in_stall = sk_v_q;

	// stage 1: offsets and direction
	logic                     v_s1;
	logic signed [DIFF_W-1:0] rx_s1, ry_s1, dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= DIFF_W'(pos_x) - DIFF_W'(start_x_q);
			ry_s1 <= DIFF_W'(pos_y) - DIFF_W'(start_y_q);
			dx_s1 <= DIFF_W'(end_x_q) - DIFF_W'(start_x_q);
			dy_s1 <= DIFF_W'(end_y_q) - DIFF_W'(start_y_q);
		end
	end

	// stage 2: products
	logic                     v_s2;
	logic signed [PROD_W-1:0] pxx_s2, pyy_s2, dxx_s2, dyy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s2 <= rx_s1 * dx_s1;
			pyy_s2 <= ry_s1 * dy_s1;
			dxx_s2 <= dx_s1 * dx_s1;
			dyy_s2 <= dy_s1 * dy_s1;
		end
	end

	// stage 3: dot product, squared length, class of t
	logic signed [REM_W-1:0] dot_c, len2_c;
	tcls_t                   cls_c;
	lgb_ctl_t                ctl_s3;
	logic [REM_W-1:0]        dot_s3, len2_s3;

	always_comb begin
		dot_c  = REM_W'(pxx_s2) + REM_W'(pyy_s2);
		len2_c = REM_W'(dxx_s2) + REM_W'(dyy_s2);
		if (len2_c == '0 || dot_c <= 0) begin
			cls_c = TCLS_ZERO;
		end else if (dot_c >= len2_c) begin
			cls_c = TCLS_ONE;
		end else begin
			cls_c = TCLS_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3.valid <= v_s2;
			ctl_s3.cls   <= cls_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3  <= $unsigned(dot_c);
			len2_s3 <= $unsigned(len2_c);
		end
	end

	lgb_ctl_t        div_ctl;
	logic [TW-1:0]   div_t;

	lgb_div #(
		.T_FRAC_BITS(T_FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (ctl_s3),
		.dot_in (dot_s3),
		.len_in (len2_s3),
		.ctl_out(div_ctl),
		.t_out  (div_t)
	);

	// stage 4: channel weights
	logic              v_s4;
	logic [MIXP_W-1:0] pa_s4 [NCHAN];
	logic [MIXP_W-1:0] pb_s4 [NCHAN];
	logic [TW-1:0]     t_inv;

	assign t_inv = ONE - div_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= div_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCHAN; i++) begin
				pa_s4[i] <= MIXP_W'(color_a_q[CHAN_W*(NCHAN-1-i) +: CHAN_W]) * MIXP_W'(t_inv);
				pb_s4[i] <= MIXP_W'(color_b_q[CHAN_W*(NCHAN-1-i) +: CHAN_W]) * MIXP_W'(div_t);
			end
		end
	end

	// stage 5: mix and brush select
	logic              v_s5;
	logic [CHAN_W-1:0] ch_s5 [NCHAN];
	logic [MIXS_W-1:0] mix_c [NCHAN];
	logic [CHAN_W-1:0] sel_c [NCHAN];

	always_comb begin
		for (int i = 0; i < NCHAN; i++) begin
			mix_c[i] = MIXS_W'(pa_s4[i]) + MIXS_W'(pb_s4[i]);
			case (brush_kind_q)
				BRUSH_SOLID:  sel_c[i] = color_a_q[CHAN_W*(NCHAN-1-i) +: CHAN_W];
				BRUSH_LINEAR: sel_c[i] = mix_c[i][T_FRAC_BITS +: CHAN_W];
				default:      sel_c[i] = CHAN_MAX;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCHAN; i++) begin
				ch_s5[i] <= sel_c[i];
			end
		end
	end

	// stage 6: alpha scaling
	logic               v_s6;
	logic [CHAN_W-1:0]  ch_s6 [NCHAN];
	logic [APROD_W-1:0] aprod_c;
	logic [OPAC_W-1:0]  ascl_c;
	logic [CHAN_W-1:0]  asat_c;

	always_comb begin
		aprod_c = APROD_W'(ch_s5[NCHAN-1]) * APROD_W'(opacity_q);
		ascl_c  = aprod_c[APROD_W-1 -: OPAC_W];
		asat_c  = ascl_c[OPAC_W-1] ? CHAN_MAX : ascl_c[CHAN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCHAN - 1; i++) begin
				ch_s6[i] <= ch_s5[i];
			end
			ch_s6[NCHAN-1] <= asat_c;
		end
	end

	// output register and skid entry
	logic              out_v_q;
	logic [CHAN_W-1:0] out_ch_q [NCHAN];
	logic [CHAN_W-1:0] sk_ch_q  [NCHAN];
	logic              push, pop;

	assign push = en && v_s6;
	assign pop  = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (sk_v_q) begin
			if (pop) begin
				sk_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				sk_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (pop) begin
				out_ch_q <= sk_ch_q;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				sk_ch_q <= ch_s6;
			end else begin
				out_ch_q <= ch_s6;
			end
		end
	end

	assign out_valid = out_v_q;
	assign red       = out_ch_q[0];
	assign green     = out_ch_q[1];
	assign blue      = out_ch_q[2];
	assign alpha     = out_ch_q[3];

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid entry held without an output transaction");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(out_v_q && out_stall && v_s6))
		else $error("skid entry filled without a stalled output");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(v_s5) && $stable(v_s6))
		else $error("pipeline advanced while the skid entry was full");

endmodule

// ===== dv/tb_linear_gradient_brush_sampler.sv =====
// ----------------------------------------------------------------------------
// tb_linear_gradient_brush_sampler
// Self-checking bench: sweeps brush settings through the configuration port,
// streams pixel positions under random bursts and output back-pressure, and
// compares every RGBA result with an in-bench prediction of the sampler.
// ----------------------------------------------------------------------------
module tb_linear_gradient_brush_sampler;
	timeunit 1ns;
	timeprecision 1ps;

	import lgb_pkg::*;

	localparam int T_FRAC   = 16;
	localparam int LATENCY  = T_FRAC + 7;
	localparam longint ONE  = longint'(1) << T_FRAC;
	localparam int RANDOM_ITEMS = 800;

	localparam logic [KIND_W-1:0] BRUSH_WHITE     = 2'd2;
	localparam logic [KIND_W-1:0] BRUSH_WHITE_ALT = 2'd3;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] a;
	} rgba_t;

	typedef struct {
		logic [KIND_W-1:0]         kind;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic [COLOR_W-1:0]        color_a;
		logic [COLOR_W-1:0]        color_b;
		logic [OPAC_W-1:0]         opacity;
	} brush_cfg_t;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} pixel_pos_t;

	typedef struct {
		pixel_pos_t pos;
		rgba_t      color;
	} pending_color_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = CFG_BRUSH_KIND;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic signed [COORD_W-1:0] pos_x = '0;
	logic signed [COORD_W-1:0] pos_y = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [CHAN_W-1:0]         red;
	logic [CHAN_W-1:0]         green;
	logic [CHAN_W-1:0]         blue;
	logic [CHAN_W-1:0]         alpha;

	brush_cfg_t     brush;
	pixel_pos_t     pos_queue[$];
	pending_color_t color_queue[$];
	pixel_pos_t     next_pos;
	pending_color_t head;
	rgba_t          got;
	bit             pos_taken = 1'b0;
	int             gap_left = 0;
	int             burst_left = 0;
	int             stall_left = 0;
	stall_mode_t    stall_mode = STALL_NONE;
	int             mismatches = 0;

	linear_gradient_brush_sampler #(
		.T_FRAC_BITS(T_FRAC)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b, input longint t);
		longint acc;
		acc = longint'(a) * (ONE - t) + longint'(b) * t;
		return CHAN_W'(acc >>> T_FRAC);
	endfunction

	function automatic rgba_t sample_brush(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py);
		rgba_t  col_a;
		rgba_t  col_b;
		rgba_t  res;
		longint dx;
		longint dy;
		longint len2;
		longint proj;
		longint t;
		longint scaled;
		col_a = brush.color_a;
		col_b = brush.color_b;
		case (brush.kind)
			BRUSH_SOLID: begin
				res = col_a;
			end
			BRUSH_LINEAR: begin
				dx = longint'(brush.end_x) - longint'(brush.start_x);
				dy = longint'(brush.end_y) - longint'(brush.start_y);
				len2 = dx * dx + dy * dy;
				proj = (longint'(px) - longint'(brush.start_x)) * dx
					+ (longint'(py) - longint'(brush.start_y)) * dy;
				if (len2 <= 0 || proj <= 0) begin
					t = 0;
				end else if (proj >= len2) begin
					t = ONE;
				end else begin
					t = (proj <<< T_FRAC) / len2;
				end
				res.r = mix_channel(col_a.r, col_b.r, t);
				res.g = mix_channel(col_a.g, col_b.g, t);
				res.b = mix_channel(col_a.b, col_b.b, t);
				res.a = mix_channel(col_a.a, col_b.a, t);
			end
			default: begin
				res = {NCHAN{CHAN_MAX}};
			end
		endcase
		scaled = (longint'(res.a) * longint'(brush.opacity)) >>> 8;
		if (scaled > 255) begin
			scaled = 255;
		end
		res.a = CHAN_W'(scaled);
		return res;
	endfunction

	// accept positions and check results
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			got = {red, green, blue, alpha};
			if (color_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result r%0d g%0d b%0d a%0d",
						got.r, got.g, got.b, got.a);
				end
			end else begin
				head = color_queue.pop_front();
				if (got !== head.color) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at (%0d,%0d): expected r%0d g%0d b%0d a%0d",
							head.pos.x, head.pos.y, head.color.r, head.color.g,
							head.color.b, head.color.a);
						$display("    got r%0d g%0d b%0d a%0d",
							got.r, got.g, got.b, got.a);
					end
				end
			end
		end
		pos_taken = in_valid && !in_stall;
		if (pos_taken) begin
			color_queue.push_back('{pos: '{x: pos_x, y: pos_y},
				color: sample_brush(pos_x, pos_y)});
		end
	end

	// drive positions in bursts separated by gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || pos_taken) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				in_valid <= 1'b0;
			end else if (pos_queue.size() > 0) begin
				next_pos = pos_queue.pop_front();
				pos_x <= next_pos.x;
				pos_y <= next_pos.y;
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left = burst_left - 1;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// back-pressure on the result side
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = (stall_mode == STALL_HOLD) ? $urandom_range(1, 30)
				: $urandom_range(10, 120);
		end
		stall_left = stall_left - 1;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= 1'b1;
		endcase
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	task automatic load_brush(input brush_cfg_t c);
		write_reg(CFG_BRUSH_KIND, {30'($urandom), c.kind});
		write_reg(CFG_START_X, {16'($urandom), c.start_x});
		write_reg(CFG_START_Y, {16'($urandom), c.start_y});
		write_reg(CFG_END_X, {16'($urandom), c.end_x});
		write_reg(CFG_END_Y, {16'($urandom), c.end_y});
		write_reg(CFG_COLOR_A, c.color_a);
		write_reg(CFG_COLOR_B, c.color_b);
		write_reg(CFG_OPACITY, {23'($urandom), c.opacity});
		@(negedge clk);
		cfg_we <= 1'b0;
		brush = c;
		@(posedge clk);
	endtask

	task automatic add_pos(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y);
		pos_queue.push_back('{x: x, y: y});
	endtask

	task automatic drain();
		while (pos_queue.size() != 0 || in_valid || color_queue.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] near_coord(input int a, input int b);
		int lo;
		int hi;
		int margin;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		margin = (hi - lo) / 4 + 16;
		lo = (lo - margin < -32768) ? -32768 : lo - margin;
		hi = (hi + margin > 32767) ? 32767 : hi + margin;
		return COORD_W'(lo + int'($urandom_range(0, hi - lo)));
	endfunction

	function automatic brush_cfg_t random_brush();
		brush_cfg_t c;
		int         pick;
		pick = $urandom_range(0, 9);
		c.kind = (pick < 2) ? BRUSH_SOLID : (pick < 8) ? BRUSH_LINEAR
			: (pick == 8) ? BRUSH_WHITE : BRUSH_WHITE_ALT;
		if ($urandom_range(0, 3) == 0) begin
			c.start_x = COORD_W'($urandom);
			c.start_y = COORD_W'($urandom);
			c.end_x = COORD_W'($urandom);
			c.end_y = COORD_W'($urandom);
		end else begin
			c.start_x = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
			c.start_y = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
			c.end_x = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
			c.end_y = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
		end
		if ($urandom_range(0, 9) == 0) begin
			c.end_x = c.start_x;
			c.end_y = c.start_y;
		end
		c.color_a = ($urandom_range(0, 9) == 0) ? '0 : COLOR_W'($urandom);
		c.color_b = ($urandom_range(0, 9) == 0) ? COLOR_RESET : COLOR_W'($urandom);
		pick = $urandom_range(0, 9);
		c.opacity = (pick == 0) ? '0 : (pick == 1) ? '1 : (pick < 5) ? OPAC_RESET
			: OPAC_W'($urandom_range(0, 511));
		return c;
	endfunction

	initial begin
		brush_cfg_t c;
		int         sent;
		int         count;
		brush = '{kind: BRUSH_SOLID, start_x: '0, start_y: '0, end_x: '0, end_y: '0,
			color_a: COLOR_RESET, color_b: COLOR_RESET, opacity: OPAC_RESET};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		add_pos(16'sh7FFF, -16'sh8000);
		add_pos(-16'sh8000, 16'sh7FFF);
		drain();

		c = brush;
		c.kind = BRUSH_LINEAR;
		c.end_x = 16'sd160;
		c.color_a = 32'h10FF_2080;
		c.color_b = 32'hF000_C0FF;
		load_brush(c);
		add_pos(-16'sd16, 16'sd5);
		add_pos(16'sd0, 16'sd0);
		add_pos(16'sd80, 16'sd0);
		add_pos(16'sd1, -16'sd3);
		add_pos(16'sd159, 16'sd0);
		add_pos(16'sd160, 16'sd0);
		add_pos(16'sh7FFF, 16'sh7FFF);
		drain();

		c.start_x = -16'sd100;
		c.start_y = 16'sd200;
		c.end_x = -16'sd100;
		c.end_y = 16'sd200;
		load_brush(c);
		add_pos(16'sh7FFF, -16'sh8000);
		add_pos(16'sd0, 16'sd0);
		drain();

		c.start_x = -16'sh8000;
		c.start_y = -16'sh8000;
		c.end_x = 16'sh7FFF;
		c.end_y = 16'sh7FFF;
		c.color_a = 32'hFF00_FF00;
		c.color_b = 32'h00FF_00FF;
		c.opacity = 9'd128;
		load_brush(c);
		add_pos(-16'sh8000, -16'sh8000);
		add_pos(16'sh7FFF, 16'sh7FFF);
		add_pos(16'sd0, 16'sd0);
		add_pos(-16'sd1, 16'sd0);
		add_pos(16'sh7FFF, -16'sh8000);
		drain();

		c.start_x = 16'sh7FFF;
		c.start_y = 16'sd0;
		c.end_x = -16'sh8000;
		c.end_y = 16'sd0;
		load_brush(c);
		add_pos(16'sd0, 16'sd0);
		add_pos(-16'sh8000, -16'sh8000);
		drain();

		c.kind = BRUSH_WHITE;
		c.opacity = '1;
		load_brush(c);
		add_pos(16'sd3, 16'sd3);
		drain();

		c.kind = BRUSH_WHITE_ALT;
		c.opacity = '0;
		load_brush(c);
		add_pos(16'sd3, 16'sd3);
		drain();

		c.kind = BRUSH_SOLID;
		c.color_a = 32'h1234_56C8;
		c.opacity = 9'd300;
		load_brush(c);
		add_pos(-16'sd7, 16'sd9);
		drain();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			load_brush(random_brush());
			count = $urandom_range(20, 80);
			repeat (count) begin
				if ($urandom_range(0, 3) == 0) begin
					add_pos(COORD_W'($urandom), COORD_W'($urandom));
				end else begin
					add_pos(near_coord(brush.start_x, brush.end_x),
						near_coord(brush.start_y, brush.end_y));
				end
			end
			sent += count;
			drain();
		end

		repeat (LATENCY + 8) @(posedge clk);
		if (mismatches == 0 && color_queue.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
